/* hw/rtl/blcf_pkg.sv */
`default_nettype none
package blcf_pkg;

    localparam int CAP_W = 40;
    localparam int KEY_W = 64;
    localparam int LEN_W = 32;
    localparam int CNT_OUT_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd1;

    localparam logic [CAP_W-1:0] CAP_RESET = 40'd4294967296;
    localparam logic POLICY_RESET = 1'b1;
    localparam logic POLICY_LRU = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE1,
        ST_MOVE2,
        ST_LEN,
        ST_MISS,
        ST_ALLOC,
        ST_INSERT,
        ST_EVCHK,
        ST_EVDO,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_MOVE1,
        OP_MOVE2,
        OP_SETHIT,
        OP_UPDLEN,
        OP_RDTAIL,
        OP_RDFREE,
        OP_INSERT,
        OP_EVICT,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic last;
        logic is_head;
        logic len_eq;
        logic over;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* hw/rtl/blcf_ram.sv */
`default_nettype none
module blcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/blcf_ctrl.sv */
`default_nettype none
module blcf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire blcf_pkg::status_t  status,
    output blcf_pkg::cmd_t          cmd
);

    blcf_pkg::state_t state_reg, state_next;
    logic full_reg, full_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blcf_pkg::ST_IDLE;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        full_next  = full_reg;
        in_ready   = 1'b0;
        cmd.op     = blcf_pkg::OP_NONE;
        unique case (state_reg)
            blcf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = blcf_pkg::OP_LOAD;
                    full_next  = 1'b0;
                    state_next = status.empty ? blcf_pkg::ST_MISS : blcf_pkg::ST_SCAN;
                end
            end
            blcf_pkg::ST_SCAN:
            begin
                cmd.op = blcf_pkg::OP_SCAN;
                if (status.match)
                begin
                    state_next = (mode == blcf_pkg::POLICY_LRU && !status.is_head) ?
                                 blcf_pkg::ST_MOVE1 : blcf_pkg::ST_LEN;
                end
                else if (status.last)
                begin
                    state_next = blcf_pkg::ST_MISS;
                end
            end
            blcf_pkg::ST_MOVE1:
            begin
                cmd.op     = blcf_pkg::OP_MOVE1;
                state_next = blcf_pkg::ST_MOVE2;
            end
            blcf_pkg::ST_MOVE2:
            begin
                cmd.op     = blcf_pkg::OP_MOVE2;
                state_next = blcf_pkg::ST_LEN;
            end
            blcf_pkg::ST_LEN:
            begin
                if (status.len_eq)
                begin
                    cmd.op     = blcf_pkg::OP_SETHIT;
                    state_next = blcf_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.op     = blcf_pkg::OP_UPDLEN;
                    state_next = blcf_pkg::ST_EVCHK;
                end
            end
            blcf_pkg::ST_MISS:
            begin
                // table full: drop the tail before taking a slot
                cmd.op     = blcf_pkg::OP_RDTAIL;
                full_next  = status.full;
                state_next = status.full ? blcf_pkg::ST_EVDO : blcf_pkg::ST_ALLOC;
            end
            blcf_pkg::ST_ALLOC:
            begin
                cmd.op     = blcf_pkg::OP_RDFREE;
                state_next = blcf_pkg::ST_INSERT;
            end
            blcf_pkg::ST_INSERT:
            begin
                cmd.op     = blcf_pkg::OP_INSERT;
                full_next  = 1'b0;
                state_next = blcf_pkg::ST_EVCHK;
            end
            blcf_pkg::ST_EVCHK:
            begin
                cmd.op     = blcf_pkg::OP_RDTAIL;
                state_next = status.over ? blcf_pkg::ST_EVDO : blcf_pkg::ST_FINISH;
            end
            blcf_pkg::ST_EVDO:
            begin
                cmd.op     = blcf_pkg::OP_EVICT;
                state_next = full_reg ? blcf_pkg::ST_ALLOC : blcf_pkg::ST_EVCHK;
            end
            blcf_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.op     = blcf_pkg::OP_OUT;
                    state_next = blcf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = blcf_pkg::ST_IDLE;
            end
        endcase
    end

    a_full_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (state_reg == blcf_pkg::ST_EVDO || state_reg == blcf_pkg::ST_ALLOC
                      || state_reg == blcf_pkg::ST_INSERT))
        else $error("full eviction flag outside the miss path");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg != blcf_pkg::ST_IDLE)
        else $error("accepted transfer did not start work");

endmodule
`default_nettype wire

/* hw/rtl/blcf_dp.sv */
`default_nettype none
module blcf_dp #(
    parameter int ENTRIES = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire blcf_pkg::cmd_t                cmd,
    output blcf_pkg::status_t                  status,
    input  wire logic [blcf_pkg::CAP_W-1:0]    capacity,
    input  wire logic [blcf_pkg::KEY_W-1:0]    key_id,
    input  wire logic [blcf_pkg::LEN_W-1:0]    object_length,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic [blcf_pkg::CNT_OUT_W-1:0]     evicted_count,
    output logic [blcf_pkg::CAP_W-1:0]         resident_bytes,
    output logic [blcf_pkg::CNT_OUT_W-1:0]     resident_entries
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = $clog2(ENTRIES + 2);
    localparam int UW = blcf_pkg::LEN_W + CW;
    localparam int KW = blcf_pkg::KEY_W;
    localparam int LW = blcf_pkg::LEN_W;
    localparam int OW = blcf_pkg::CNT_OUT_W;

    logic [KW-1:0] key_reg;
    logic [LW-1:0] len_reg;
    logic [IW-1:0] cur_reg, head_reg, tail_reg, fprev_reg, fnext_reg;
    logic [IW-1:0] cnt_reg;
    logic [LW-1:0] flen_reg;
    logic          is_tail_reg, hit_reg;
    logic [EW-1:0] ev_reg;
    logic [CW-1:0] total_reg, fill_reg, free_cnt_reg;
    logic [UW-1:0] used_reg;
    logic          out_valid_reg;

    logic [KW-1:0] key_rd;
    logic [LW-1:0] len_rd;
    logic [IW-1:0] prev_rd, next_rd, free_rd;
    logic [IW-1:0] node_raddr, free_raddr, slot;

    logic          key_we, len_we, next_we, prev_we, free_we;
    logic [IW-1:0] len_wa, next_wa, next_wd, prev_wa, prev_wd;
    logic [LW-1:0] len_wd;

    blcf_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key (.clk(clk), .we(key_we), .waddr(slot),
        .wdata(key_reg), .raddr(node_raddr), .rdata(key_rd));
    blcf_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_len (.clk(clk), .we(len_we), .waddr(len_wa),
        .wdata(len_wd), .raddr(node_raddr), .rdata(len_rd));
    blcf_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_next (.clk(clk), .we(next_we), .waddr(next_wa),
        .wdata(next_wd), .raddr(node_raddr), .rdata(next_rd));
    blcf_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_prev (.clk(clk), .we(prev_we), .waddr(prev_wa),
        .wdata(prev_wd), .raddr(node_raddr), .rdata(prev_rd));
    blcf_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_free (.clk(clk), .we(free_we),
        .waddr(free_cnt_reg[IW-1:0]), .wdata(tail_reg), .raddr(free_raddr),
        .rdata(free_rd));

    assign free_raddr = IW'(free_cnt_reg - 1'b1);
    // freed slots are reused first, otherwise fresh slots in order
    assign slot = (free_cnt_reg != '0) ? free_rd : fill_reg[IW-1:0];

    always_comb
    begin
        case (cmd.op)
            blcf_pkg::OP_LOAD:   node_raddr = head_reg;
            blcf_pkg::OP_SCAN:   node_raddr = next_rd;
            default:             node_raddr = tail_reg;
        endcase
    end

    always_comb
    begin
        key_we  = 1'b0;
        len_we  = 1'b0;
        next_we = 1'b0;
        prev_we = 1'b0;
        free_we = 1'b0;
        len_wa  = slot;
        len_wd  = len_reg;
        next_wa = slot;
        next_wd = head_reg;
        prev_wa = head_reg;
        prev_wd = slot;
        case (cmd.op)
            blcf_pkg::OP_MOVE1:
            begin
                next_we = 1'b1;
                next_wa = fprev_reg;
                next_wd = fnext_reg;
                prev_we = !is_tail_reg;
                prev_wa = fnext_reg;
                prev_wd = fprev_reg;
            end
            blcf_pkg::OP_MOVE2:
            begin
                next_we = 1'b1;
                next_wa = cur_reg;
                prev_we = 1'b1;
                prev_wd = cur_reg;
            end
            blcf_pkg::OP_UPDLEN:
            begin
                len_we = 1'b1;
                len_wa = cur_reg;
            end
            blcf_pkg::OP_INSERT:
            begin
                key_we  = 1'b1;
                len_we  = 1'b1;
                next_we = 1'b1;
                prev_we = (total_reg != '0);
            end
            blcf_pkg::OP_EVICT:
            begin
                free_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            total_reg     <= '0;
            fill_reg      <= '0;
            free_cnt_reg  <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                blcf_pkg::OP_MOVE1:
                begin
                    if (is_tail_reg)
                    begin
                        tail_reg <= fprev_reg;
                    end
                end
                blcf_pkg::OP_MOVE2:
                begin
                    head_reg <= cur_reg;
                end
                blcf_pkg::OP_UPDLEN:
                begin
                    used_reg <= used_reg - UW'(flen_reg) + UW'(len_reg);
                end
                blcf_pkg::OP_INSERT:
                begin
                    head_reg  <= slot;
                    if (total_reg == '0)
                    begin
                        tail_reg <= slot;
                    end
                    total_reg <= total_reg + 1'b1;
                    used_reg  <= used_reg + UW'(len_reg);
                    if (free_cnt_reg != '0)
                    begin
                        free_cnt_reg <= free_cnt_reg - 1'b1;
                    end
                    else
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
                blcf_pkg::OP_EVICT:
                begin
                    used_reg     <= used_reg - UW'(len_rd);
                    tail_reg     <= prev_rd;
                    total_reg    <= total_reg - 1'b1;
                    free_cnt_reg <= free_cnt_reg + 1'b1;
                end
                blcf_pkg::OP_OUT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            blcf_pkg::OP_LOAD:
            begin
                key_reg <= key_id;
                len_reg <= object_length;
                cur_reg <= head_reg;
                cnt_reg <= '0;
                hit_reg <= 1'b0;
                ev_reg  <= '0;
            end
            blcf_pkg::OP_SCAN:
            begin
                if (status.match)
                begin
                    flen_reg    <= len_rd;
                    fprev_reg   <= prev_rd;
                    fnext_reg   <= next_rd;
                    is_tail_reg <= status.last;
                end
                else
                begin
                    cur_reg <= next_rd;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            blcf_pkg::OP_SETHIT:
            begin
                hit_reg <= 1'b1;
            end
            blcf_pkg::OP_EVICT:
            begin
                ev_reg <= ev_reg + 1'b1;
            end
            blcf_pkg::OP_OUT:
            begin
                hit              <= hit_reg;
                evicted_count    <= (32'(ev_reg) > 32'd511) ? {OW{1'b1}} : OW'(ev_reg);
                resident_bytes   <= (64'(used_reg) > 64'hFF_FFFF_FFFF) ?
                                    {blcf_pkg::CAP_W{1'b1}} : blcf_pkg::CAP_W'(used_reg);
                resident_entries <= (32'(total_reg) > 32'd511) ?
                                    {OW{1'b1}} : OW'(total_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        status.empty    = (total_reg == '0);
        status.full     = (32'(total_reg) == ENTRIES);
        status.match    = (key_rd == key_reg);
        status.last     = (CW'(cnt_reg) == total_reg - 1'b1);
        status.is_head  = (cnt_reg == '0);
        status.len_eq   = (flen_reg == len_reg);
        status.over     = (64'(capacity) < 64'(used_reg)) && (total_reg != '0);
        status.out_free = !out_valid_reg || out_ready;
    end

    a_slot_count: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(total_reg) + 32'(free_cnt_reg)) == 32'(fill_reg))
        else $error("resident plus free slots differ from allocated slots");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= ENTRIES)
        else $error("resident entry count above table size");

    a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg == '0) |-> (used_reg == '0))
        else $error("bytes resident with no entries");

endmodule
`default_nettype wire

/* hw/rtl/byte_capacity_lru_fifo_cache_unit.sv */
// on a hit the lookup walks the list nodes for the key, one per cycle through the node memories;
// a length mismatch adds a length update and an eviction check, a miss adds the slot allocation
// and head insert, an lru move adds its own steps, as does each tail eviction and the eviction
// that makes room in a full table; a full output register stalls the end
// throughput: one access at a time; next transfer taken in the cycle after the result is
// registered; reset: empty table, zero resident bytes,
// capacity 4294967296, lru mode; no clearing pass
`default_nettype none
module byte_capacity_lru_fifo_cache_unit #(
    parameter int ENTRIES = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [blcf_pkg::KEY_W-1:0]          key_id,
    input  wire logic [blcf_pkg::LEN_W-1:0]          object_length,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     hit,
    output logic [blcf_pkg::CNT_OUT_W-1:0]           evicted_count,
    output logic [blcf_pkg::CAP_W-1:0]               resident_bytes,
    output logic [blcf_pkg::CNT_OUT_W-1:0]           resident_entries,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [blcf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [blcf_pkg::CAP_W-1:0]          cfg_data
);

    logic [blcf_pkg::CAP_W-1:0] capacity_reg;
    logic                       policy_reg;
    blcf_pkg::cmd_t             cmd;
    blcf_pkg::status_t          status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= blcf_pkg::CAP_RESET;
            policy_reg   <= blcf_pkg::POLICY_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                blcf_pkg::CFG_CAPACITY: capacity_reg <= cfg_data;
                blcf_pkg::CFG_POLICY:   policy_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    blcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (policy_reg),
        .status   (status),
        .cmd      (cmd)
    );

    blcf_dp #(.ENTRIES(ENTRIES)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .capacity         (capacity_reg),
        .key_id           (key_id),
        .object_length    (object_length),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .hit              (hit),
        .evicted_count    (evicted_count),
        .resident_bytes   (resident_bytes),
        .resident_entries (resident_entries)
    );

endmodule
`default_nettype wire
